>>> src/barn_pkg.sv
// Package: shared types, constants and the divider step for the bin normalizer.
package barn_pkg;

  localparam int BIN_W   = 4;
  localparam int MAG_W   = 16;
  localparam int COEF_W  = 17;
  localparam int LEVEL_W = 17;
  localparam int CFG_IDX_W = 2;

  localparam logic [COEF_W-1:0] Q_ONE = 17'd65536;

  localparam logic [COEF_W-1:0] FAST_RST = 17'd32768;
  localparam logic [COEF_W-1:0] SLOW_RST = 17'd6554;
  localparam logic [COEF_W-1:0] LMIN_RST = 17'd0;
  localparam logic [COEF_W-1:0] LMAX_RST = 17'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FAST_COEFF = 2'd0,
    REG_SLOW_COEFF = 2'd1,
    REG_LEVEL_MIN  = 2'd2,
    REG_LEVEL_MAX  = 2'd3
  } cfg_reg_t;

  // Accepted item waiting for its smoothing step
  typedef struct packed {
    logic [BIN_W-1:0] bin;
    logic [MAG_W-1:0] mag;
    logic [MAG_W-1:0] peak;
    logic             in_range;
  } smooth_stage_t;

  // Smoothed value on its way into the divider
  typedef struct packed {
    logic [BIN_W-1:0] bin;
    logic [MAG_W-1:0] sm;
    logic [MAG_W-1:0] peak;
  } norm_stage_t;

  // One divider stage: partial remainder and quotient
  typedef struct packed {
    logic [BIN_W-1:0] bin;
    logic             force_hi;
    logic [MAG_W-1:0] peak;
    logic [MAG_W-1:0] rem;
    logic [MAG_W-1:0] quo;
  } div_stage_t;

  typedef struct packed {
    logic [BIN_W-1:0]   bin;
    logic [LEVEL_W-1:0] level;
  } out_stage_t;

  function automatic logic [COEF_W-1:0] sat_one(input logic [COEF_W-1:0] v);
    return (v > Q_ONE) ? Q_ONE : v;
  endfunction

  // Four restoring division steps; dividend low bits are all zero (sm << 16).
  function automatic div_stage_t div_step4(input div_stage_t d);
    div_stage_t    r;
    logic [MAG_W:0] r2;
    logic           qb;
    r = d;
    for (int i = 0; i < 4; i++) begin
      r2 = {r.rem, 1'b0};
      qb = 1'b0;
      if (r2 >= {1'b0, r.peak}) begin
        r2 = r2 - {1'b0, r.peak};
        qb = 1'b1;
      end
      r.rem = r2[MAG_W-1:0];
      r.quo = {r.quo[MAG_W-2:0], qb};
    end
    return r;
  endfunction

endpackage

>>> src/barn_ifs.sv
// Interfaces: input bin channel and result channel, valid/ready with payload.
interface barn_in_if;
  logic                       valid;
  logic                       ready;
  logic [barn_pkg::BIN_W-1:0] bin_index;
  logic [barn_pkg::MAG_W-1:0] magnitude;
  logic [barn_pkg::MAG_W-1:0] bin_peak;

  modport source (output valid, output bin_index, output magnitude, output bin_peak,
                  input ready);
  modport sink   (input valid, input bin_index, input magnitude, input bin_peak,
                  output ready);
endinterface

interface barn_out_if;
  logic                         valid;
  logic                         ready;
  logic [barn_pkg::BIN_W-1:0]   out_bin;
  logic [barn_pkg::LEVEL_W-1:0] level;

  modport source (output valid, output out_bin, output level, input ready);
  modport sink   (input valid, input out_bin, input level, output ready);
endinterface

>>> src/bin_attack_release_normalizer_top.sv
// Top level: per-bin attack/release smoother with peak normalization and clamp.
//
//   channel  | dir | handshake         | payload
//   ---------+-----+-------------------+----------------------------------------
//   in_ch    | in  | valid/ready       | bin_index[3:0] magnitude[15:0] bin_peak[15:0]
//   out_ch   | out | valid/ready       | out_bin[3:0] level[16:0] (Q16)
//   cfg_*    | in  | cfg_we, no stall  | cfg_index[1:0] cfg_data[16:0]
//
// One transaction per cycle sustained while out_ch.ready stays high; registers in
// order: input and store read, blend, four 4-bit divider stages, output.
// The per-bin recurrence: store read at accept, blend in the next stage, write
// back with a one-entry bypass for same-bin neighbors.
// Reset (rst_n, sync) clears all stage valids and the per-bin valid bits, so
// every bin reads as zero; config returns to its reset values. No clear sweep.
// Each stage holds when the next is full and stalled; bubbles are squeezed out.
module bin_attack_release_normalizer_top #(
  parameter int NUM_BINS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  barn_in_if.sink                           in_ch,
  barn_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [barn_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [barn_pkg::COEF_W-1:0]       cfg_data
);

  localparam int AW     = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int NDIV   = 4;

  // ---------------- configuration registers ----------------
  logic [barn_pkg::COEF_W-1:0] fast_r, slow_r, lmin_r, lmax_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fast_r <= barn_pkg::FAST_RST;
      slow_r <= barn_pkg::SLOW_RST;
      lmin_r <= barn_pkg::LMIN_RST;
      lmax_r <= barn_pkg::LMAX_RST;
    end else if (cfg_we) begin
      case (barn_pkg::cfg_reg_t'(cfg_index))
        barn_pkg::REG_FAST_COEFF: fast_r <= cfg_data;
        barn_pkg::REG_SLOW_COEFF: slow_r <= cfg_data;
        barn_pkg::REG_LEVEL_MIN:  lmin_r <= cfg_data;
        barn_pkg::REG_LEVEL_MAX:  lmax_r <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [barn_pkg::COEF_W-1:0] lo_sat, hi_sat;
  assign lo_sat = barn_pkg::sat_one(lmin_r);
  assign hi_sat = barn_pkg::sat_one(lmax_r);

  // ---------------- stage registers and ready chain ----------------
  barn_pkg::smooth_stage_t s1_r;
  logic                    s1_v_r;
  barn_pkg::norm_stage_t   s2_r;
  logic                    s2_v_r;
  barn_pkg::div_stage_t    d_r   [NDIV];
  logic [NDIV-1:0]         d_v_r;
  barn_pkg::out_stage_t    out_r;
  logic                    out_v_r;

  logic            out_rdy, s2_rdy, s1_rdy;
  logic [NDIV-1:0] d_rdy;

  assign out_rdy = !out_v_r || out_ch.ready;

  always_comb begin
    d_rdy[NDIV-1] = !d_v_r[NDIV-1] || out_rdy;
    for (int k = NDIV - 2; k >= 0; k--) begin
      d_rdy[k] = !d_v_r[k] || d_rdy[k+1];
    end
  end

  assign s2_rdy = !s2_v_r || d_rdy[0];
  assign s1_rdy = !s1_v_r || s2_rdy;

  assign in_ch.ready = s1_rdy;

  logic in_acc, s1_adv;
  assign in_acc = in_ch.valid && s1_rdy;
  assign s1_adv = s1_v_r && s2_rdy;

  // ---------------- per-bin smoothed store ----------------
  logic [barn_pkg::MAG_W-1:0] mem [NUM_BINS];
  logic [NUM_BINS-1:0]        vld_r;
  logic [barn_pkg::MAG_W-1:0] rd_data_r;
  logic                       rd_vld_r;
  logic                       byp_r;
  logic [barn_pkg::MAG_W-1:0] byp_data_r;

  logic            in_range;
  logic [AW-1:0]   in_addr, s1_addr;
  logic            s1_wr;
  logic [barn_pkg::MAG_W-1:0] sm_s1;

  assign in_range = (32'(in_ch.bin_index) < NUM_BINS);
  assign in_addr  = AW'(in_ch.bin_index);
  assign s1_addr  = AW'(s1_r.bin);
  assign s1_wr    = s1_adv && s1_r.in_range;

  always_ff @(posedge clk) begin
    if (s1_wr) begin
      mem[s1_addr] <= sm_s1;
    end
    if (in_acc) begin
      rd_data_r  <= mem[in_addr];
      // the store write of this same edge is not seen by the read: forward it
      byp_r      <= s1_wr && (s1_r.bin == in_ch.bin_index);
      byp_data_r <= sm_s1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (s1_wr) begin
      vld_r[s1_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_vld_r <= vld_r[in_addr];
    end
  end

  // ---------------- stage 1: attack/release blend ----------------
  logic [barn_pkg::MAG_W-1:0]      prev;
  logic [barn_pkg::COEF_W-1:0]     coef;
  logic signed [barn_pkg::MAG_W:0] diff;
  logic signed [34:0]              prod;
  logic signed [34:0]              rnd;
  logic signed [18:0]              sum;

  always_comb begin
    if (!s1_r.in_range) begin
      prev = '0;
    end else if (byp_r) begin
      prev = byp_data_r;
    end else if (rd_vld_r) begin
      prev = rd_data_r;
    end else begin
      prev = '0;
    end
    coef  = barn_pkg::sat_one((s1_r.mag > prev) ? fast_r : slow_r);
    diff  = $signed({1'b0, s1_r.mag}) - $signed({1'b0, prev});
    // prev*65536 + a*(mag-prev) + half, then >> 16
    prod  = $signed({1'b0, coef}) * diff;
    rnd   = prod + 35'sd32768;
    sum   = $signed({3'b000, prev}) + rnd[34:16];
    sm_s1 = sum[barn_pkg::MAG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_rdy) begin
      s1_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r.bin      <= in_ch.bin_index;
      s1_r.mag      <= in_ch.magnitude;
      s1_r.peak     <= in_ch.bin_peak;
      s1_r.in_range <= in_range;
    end
  end

  // ---------------- stage 2: smoothed value ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_rdy) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_r.bin  <= s1_r.bin;
      s2_r.sm   <= sm_s1;
      s2_r.peak <= s1_r.peak;
    end
  end

  // ---------------- divider stages ----------------
  // sm >= peak (zero peak included) gives a ratio of one or more: level = max clamp.
  // Otherwise the quotient has 16 bits, four per stage.
  barn_pkg::div_stage_t d_init;
  barn_pkg::div_stage_t d_nxt [NDIV];

  always_comb begin
    d_init.bin      = s2_r.bin;
    d_init.force_hi = (s2_r.sm >= s2_r.peak);
    d_init.peak     = s2_r.peak;
    d_init.rem      = s2_r.sm;
    d_init.quo      = '0;
    d_nxt[0]        = barn_pkg::div_step4(d_init);
    for (int k = 1; k < NDIV; k++) begin
      d_nxt[k] = barn_pkg::div_step4(d_r[k-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_v_r <= '0;
    end else begin
      if (d_rdy[0]) begin
        d_v_r[0] <= s2_v_r;
      end
      for (int k = 1; k < NDIV; k++) begin
        if (d_rdy[k]) begin
          d_v_r[k] <= d_v_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_v_r && d_rdy[0]) begin
      d_r[0] <= d_nxt[0];
    end
    for (int k = 1; k < NDIV; k++) begin
      if (d_v_r[k-1] && d_rdy[k]) begin
        d_r[k] <= d_nxt[k];
      end
    end
  end

  // ---------------- clamp and output register ----------------
  logic [barn_pkg::LEVEL_W-1:0] q_ext, lvl_lo, level_nxt;

  always_comb begin
    q_ext  = {1'b0, d_r[NDIV-1].quo};
    lvl_lo = (q_ext < lo_sat) ? lo_sat : q_ext;
    if (d_r[NDIV-1].force_hi) begin
      level_nxt = hi_sat;
    end else begin
      level_nxt = (lvl_lo > hi_sat) ? hi_sat : lvl_lo;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_rdy) begin
      out_v_r <= d_v_r[NDIV-1];
    end
  end

  always_ff @(posedge clk) begin
    if (d_v_r[NDIV-1] && out_rdy) begin
      out_r.bin   <= d_r[NDIV-1].bin;
      out_r.level <= level_nxt;
    end
  end

  assign out_ch.valid   = out_v_r;
  assign out_ch.out_bin = out_r.bin;
  assign out_ch.level   = out_r.level;

  // ---------------- assertions ----------------
  a_level_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (out_r.level <= hi_sat))
    else $error("level above max clamp");

  a_level_ge_min: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && (lo_sat <= hi_sat)) |-> (out_r.level >= lo_sat))
    else $error("level below min clamp with ordered bounds");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !s2_rdy) |=> (s1_v_r && $stable(s1_r)))
    else $error("stalled blend stage lost its item");

  a_no_write_stall: assert property (@(posedge clk) disable iff (!rst_n)
    s1_wr |-> (s1_v_r && s1_r.in_range && s2_rdy))
    else $error("store written without stage advance");

endmodule

>>> tb/bin_attack_release_normalizer_top_test.sv
`timescale 1ns / 1ps
// Testbench: bin normalizer against an envelope predictor, random stalls on both channels.

typedef struct {
  logic [barn_pkg::BIN_W-1:0]   bin;
  logic [barn_pkg::LEVEL_W-1:0] level;
} level_item_t;

class envelope_scoreboard;
  logic [barn_pkg::COEF_W-1:0] attack_w;
  logic [barn_pkg::COEF_W-1:0] release_w;
  logic [barn_pkg::COEF_W-1:0] floor_q;
  logic [barn_pkg::COEF_W-1:0] ceil_q;
  logic [barn_pkg::MAG_W-1:0]  envelope [16];
  level_item_t                 pending_levels [$];
  int                          errors;

  function new();
    attack_w  = barn_pkg::FAST_RST;
    release_w = barn_pkg::SLOW_RST;
    floor_q   = barn_pkg::LMIN_RST;
    ceil_q    = barn_pkg::LMAX_RST;
    foreach (envelope[i]) envelope[i] = '0;
    errors = 0;
  endfunction

  // Anything above unity counts as unity.
  function logic [barn_pkg::COEF_W-1:0] cap_unity(logic [barn_pkg::COEF_W-1:0] v);
    return (v > barn_pkg::Q_ONE) ? barn_pkg::Q_ONE : v;
  endfunction

  function void write_reg(barn_pkg::cfg_reg_t idx, logic [barn_pkg::COEF_W-1:0] v);
    case (idx)
      barn_pkg::REG_FAST_COEFF: attack_w  = v;
      barn_pkg::REG_SLOW_COEFF: release_w = v;
      barn_pkg::REG_LEVEL_MIN:  floor_q   = v;
      barn_pkg::REG_LEVEL_MAX:  ceil_q    = v;
      default: ;
    endcase
  endfunction

  // Blend into the bin's envelope, normalize by the peak, clamp; queue the level.
  function void accept_bin(logic [barn_pkg::BIN_W-1:0] b, logic [barn_pkg::MAG_W-1:0] m,
                           logic [barn_pkg::MAG_W-1:0] p);
    logic [barn_pkg::MAG_W-1:0]  prev;
    logic [barn_pkg::COEF_W-1:0] w;
    logic [barn_pkg::COEF_W-1:0] lo;
    logic [barn_pkg::COEF_W-1:0] hi;
    logic [63:0]                 acc;
    logic [barn_pkg::MAG_W-1:0]  sm;
    logic [63:0]                 ratio;
    level_item_t                 item;
    prev = envelope[b];
    w = cap_unity((m > prev) ? attack_w : release_w);
    lo = cap_unity(floor_q);
    hi = cap_unity(ceil_q);
    acc = 64'(w) * 64'(m) + 64'(barn_pkg::Q_ONE - w) * 64'(prev) + 64'd32768;
    sm = acc[31:16];
    envelope[b] = sm;
    if (p == '0) begin
      ratio = 64'(hi);
    end else begin
      ratio = (64'(sm) << 16) / 64'(p);
      if (ratio < 64'(lo)) ratio = 64'(lo);
      if (ratio > 64'(hi)) ratio = 64'(hi);
    end
    item.bin = b;
    item.level = ratio[barn_pkg::LEVEL_W-1:0];
    pending_levels.push_back(item);
  endfunction

  function void check_level(logic [barn_pkg::BIN_W-1:0] b, logic [barn_pkg::LEVEL_W-1:0] lvl);
    level_item_t exp_item;
    if (pending_levels.size() == 0) begin
      $error("unexpected result: out_bin %0d level %0d", b, lvl);
      errors++;
      return;
    end
    exp_item = pending_levels.pop_front();
    if (exp_item.bin !== b) begin
      $error("out_bin: expected %0d, actual %0d", exp_item.bin, b);
      errors++;
    end
    if (exp_item.level !== lvl) begin
      $error("level: expected %0d, actual %0d", exp_item.level, lvl);
      errors++;
    end
  endfunction
endclass

module bin_attack_release_normalizer_top_test;
  // Worst case is roughly 2000 transactions x (long sender gap + long sink stall
  // + pipeline); the limit leaves ample headroom.
  localparam int CYCLE_LIMIT  = 1000000;
  // Pipeline is 7 deep; settle a bit longer before touching config or ending.
  localparam int DRAIN_CYCLES = 12;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 235;

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           cfg_we;
  logic [barn_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [barn_pkg::COEF_W-1:0]    cfg_data;

  barn_in_if  in_ch ();
  barn_out_if out_ch ();

  envelope_scoreboard board = new();

  // When set, neither side inserts bubbles or stalls.
  bit steady = 1'b1;
  int cycles = 0;
  int stall_left = 0;

  bin_attack_release_normalizer_top #(.NUM_BINS(16)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("bin_attack_release_normalizer_top: mismatch");
      $finish;
    end
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result side: ready toggles at the falling edge with random stall lengths.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  // Sample completed result transactions at the rising edge.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      board.check_level(out_ch.out_bin, out_ch.level);
  end

  // Valid stays high across back-to-back transactions; lowered only for a gap or a drain.
  task automatic send_bin(input logic [barn_pkg::BIN_W-1:0] b,
                          input logic [barn_pkg::MAG_W-1:0] m,
                          input logic [barn_pkg::MAG_W-1:0] p);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.bin_index <= b;
    in_ch.magnitude <= m;
    in_ch.bin_peak  <= p;
    do @(posedge clk); while (!in_ch.ready);
    board.accept_bin(b, m, p);
  endtask

  // Wait until every queued level has come back and the pipe is empty.
  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (board.pending_levels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input barn_pkg::cfg_reg_t idx,
                           input logic [barn_pkg::COEF_W-1:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    board.write_reg(idx, v);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_all(input logic [barn_pkg::COEF_W-1:0] fast,
                         input logic [barn_pkg::COEF_W-1:0] slow,
                         input logic [barn_pkg::COEF_W-1:0] lmin,
                         input logic [barn_pkg::COEF_W-1:0] lmax);
    write_cfg(barn_pkg::REG_FAST_COEFF, fast);
    write_cfg(barn_pkg::REG_SLOW_COEFF, slow);
    write_cfg(barn_pkg::REG_LEVEL_MIN, lmin);
    write_cfg(barn_pkg::REG_LEVEL_MAX, lmax);
  endtask

  // Register value: extremes (incl. above unity) or anything in range.
  function automatic logic [barn_pkg::COEF_W-1:0] pick_reg();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return barn_pkg::Q_ONE;
      2: return '1;
      3: return barn_pkg::COEF_W'($urandom_range(0, 131071));
      default: return barn_pkg::COEF_W'($urandom_range(0, 65536));
    endcase
  endfunction

  // Magnitudes hug the stored envelope often so rise/fall/equal all get hit.
  function automatic logic [barn_pkg::MAG_W-1:0] pick_mag(input logic [barn_pkg::BIN_W-1:0] b);
    logic [barn_pkg::MAG_W-1:0] env;
    env = board.envelope[b];
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return env;
      3: return env + 16'd1;
      4: return env - 16'd1;
      5: return barn_pkg::MAG_W'(1) << $urandom_range(0, 15);
      default: return barn_pkg::MAG_W'($urandom());
    endcase
  endfunction

  // Peaks near the envelope keep the ratio inside the clamp window.
  function automatic logic [barn_pkg::MAG_W-1:0] pick_peak(input logic [barn_pkg::BIN_W-1:0] b);
    logic [barn_pkg::MAG_W-1:0] env;
    env = board.envelope[b];
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return 16'd1;
      3, 4, 5: return env + barn_pkg::MAG_W'($urandom_range(0, 4096));
      6: return barn_pkg::MAG_W'($urandom_range(1, 255));
      default: return barn_pkg::MAG_W'($urandom());
    endcase
  endfunction

  initial begin
    int phase;
    int k;
    int span;
    logic [barn_pkg::BIN_W-1:0]  bin_a;
    logic [barn_pkg::BIN_W-1:0]  bin_b;
    logic [barn_pkg::BIN_W-1:0]  b;
    logic [barn_pkg::COEF_W-1:0] lmin;
    logic [barn_pkg::COEF_W-1:0] lmax;

    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = barn_pkg::REG_FAST_COEFF;
    cfg_data        = '0;
    in_ch.valid     = 1'b0;
    in_ch.bin_index = '0;
    in_ch.magnitude = '0;
    in_ch.bin_peak  = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset config, back to back. Rise, zero peak, fall, equal value,
    // clamp at max, tiny ratio, zero magnitude on a zero envelope.
    send_bin(4'd0, 16'hFFFF, 16'hFFFF);
    send_bin(4'd0, 16'hFFFF, 16'h0000);
    send_bin(4'd0, 16'h0000, 16'h0001);
    send_bin(4'd0, board.envelope[0], 16'h0001);
    send_bin(4'd15, 16'hFFFF, 16'h0001);
    send_bin(4'd15, 16'h0001, 16'hFFFF);
    send_bin(4'd8, 16'h0000, 16'h0000);
    send_bin(4'd8, 16'h0000, 16'hFFFF);

    // Unity attack, zero release: envelope jumps up and never decays.
    drain();
    set_all(barn_pkg::Q_ONE, '0, '0, barn_pkg::Q_ONE);
    send_bin(4'd3, 16'd40000, 16'd40000);
    send_bin(4'd3, 16'd1000, 16'd20000);

    // Everything above unity saturates: weights act as 1, both bounds as 1.
    drain();
    set_all('1, '1, '1, '1);
    send_bin(4'd5, 16'd12345, 16'hFFFF);
    send_bin(4'd5, 16'd100, 16'h0000);

    // Crossed bounds: max wins. Zero attack holds the envelope on a rise.
    drain();
    set_all('0, 17'd32768, 17'd50000, 17'd10000);
    send_bin(4'd5, 16'hFFFF, 16'd100);
    send_bin(4'd6, 16'd30000, 16'hFFFF);
    send_bin(4'd6, 16'd30000, 16'd3);

    // Both bounds zero: every level is zero, zero peak included.
    drain();
    set_all(17'd20000, 17'd40000, '0, '0);
    send_bin(4'd9, 16'hFFFF, 16'hFFFF);
    send_bin(4'd9, 16'h0000, 16'h0000);

    // Same bin back to back exercises the write-back bypass.
    drain();
    set_all(barn_pkg::FAST_RST, barn_pkg::SLOW_RST, 17'd1000, 17'd60000);
    send_bin(4'd10, 16'd50000, 16'd60000);
    send_bin(4'd10, 16'd50000, 16'd60000);
    send_bin(4'd10, 16'd10, 16'd60000);
    send_bin(4'd10, barn_pkg::MAG_W'($urandom()), 16'd2);

    // Random phases: fresh config each, some phases pinned to one or two bins
    // so the same-bin path is hammered, every third phase with no idling.
    for (phase = 0; phase < PHASES; phase++) begin
      drain();
      lmin = ($urandom_range(0, 2) == 0) ? pick_reg()
                                          : barn_pkg::COEF_W'($urandom_range(0, 8192));
      lmax = ($urandom_range(0, 2) == 0) ? pick_reg()
                                          : barn_pkg::COEF_W'(65536 - $urandom_range(0, 8192));
      set_all(pick_reg(), pick_reg(), lmin, lmax);
      steady = (phase % 3 == 2);
      span   = $urandom_range(0, 2);
      bin_a  = barn_pkg::BIN_W'($urandom());
      bin_b  = barn_pkg::BIN_W'($urandom());
      for (k = 0; k < PHASE_ITEMS; k++) begin
        case (span)
          0: b = barn_pkg::BIN_W'($urandom());
          1: b = $urandom_range(0, 1) ? bin_a : bin_b;
          default: b = bin_a;
        endcase
        send_bin(b, pick_mag(b), pick_peak(b));
      end
    end

    drain();
    if (board.errors == 0 && board.pending_levels.size() == 0) begin
      $display("bin_attack_release_normalizer_top: match");
    end else begin
      $display("bin_attack_release_normalizer_top: mismatch");
    end
    $finish;
  end
endmodule

>>> files.f
src/barn_pkg.sv
src/barn_ifs.sv
src/bin_attack_release_normalizer_top.sv
tb/bin_attack_release_normalizer_top_test.sv
